/* hdl/vector_arith_unit_core_defines.svh */
// ---------------------------------------------------------------------------
// Vector arithmetic unit: assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef VECTOR_ARITH_UNIT_CORE_DEFINES_SVH
`define VECTOR_ARITH_UNIT_CORE_DEFINES_SVH

// antecedent implies consequent on the same clock edge
`define VAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define VAU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* hdl/vau_pkg.sv */
// ---------------------------------------------------------------------------
// vau_pkg
// Types, constants and helper functions of the vector arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none

package vau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NLANE          = 4;

    // divider: quotient bits and divisor width (magnitude reaches 2^32)
    localparam int QBITS   = 33;
    localparam int DVW     = 33;
    localparam int SQ_STG  = 32;
    localparam int DIV_STG = QBITS + 1;

    // pipeline timing, counted in register stages after the accepting edge
    localparam int T_SQ    = 3 + SQ_STG;
    localparam int T_DIV   = T_SQ + DIV_STG;
    localparam int LATENCY = T_DIV + 1;

    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_SUB   = 4'd1,
        FN_DOT   = 4'd2,
        FN_CROSS = 4'd3,
        FN_SCALE = 4'd4,
        FN_ADDS  = 4'd5,
        FN_SUBS  = 4'd6,
        FN_DIV   = 4'd7,
        FN_NORM  = 4'd8
    } t_func;

    typedef enum logic [1:0] {
        FLT_NONE = 2'd0,
        FLT_DIVZ = 2'd1,
        FLT_SAT  = 2'd2
    } t_fault;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        t_func            func;
        logic [NLANE-1:0] lane_use;
        logic [NLANE-1:0] out_en;
        logic [NLANE-1:0] azero;
        logic [NLANE-1:0] aneg;
        logic             bzero;
        logic             bneg;
    } t_ctrl;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat;

    // cross product operand lanes: a[0]*b[1] - a[2]*b[3]
    localparam logic [1:0] CP [3][4] = '{
        '{2'd1, 2'd2, 2'd2, 2'd1},
        '{2'd2, 2'd0, 2'd0, 2'd2},
        '{2'd0, 2'd1, 2'd1, 2'd0}
    };

    function automatic logic [31:0] max_val(input int dw);
        return 32'((64'd1 << (dw - 1)) - 64'd1);
    endfunction

    function automatic logic [31:0] min_val(input int dw);
        return ~max_val(dw);
    endfunction

    // clamp to the signed dw-bit range
    function automatic t_sat sat_clamp(input logic signed [65:0] v, input int dw);
        logic signed [65:0] mx;
        logic signed [65:0] mn;
        t_sat               s;
        mx = $signed({34'd0, max_val(dw)});
        mn = ~mx;
        if (v > mx) begin
            s.val = max_val(dw);
            s.sat = 1'b1;
        end else if (v < mn) begin
            s.val = min_val(dw);
            s.sat = 1'b1;
        end else begin
            s.val = v[31:0];
            s.sat = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* hdl/vector_arith_unit_core.sv */
// ---------------------------------------------------------------------------
// vector_arith_unit_core
// Vector ALU on 2..4 lanes of signed fixed point: add, sub, dot, cross,
// scale, add/sub scalar, divide by scalar, normalize. Saturating.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   command  | start / busy     | i_func, i_dim, i_a_x..i_a_w, i_b_x..i_b_w
//   result   | o_done strobe    | o_r_x..o_r_w, o_fault
//
// One item per cycle; busy stays low, every cycle can start a transfer.
// Every opcode takes the same path, its depth set by the 32-stage
// square root followed by the 34-stage divider used by normalize/divide.
// Reset clears only the valid line; results leave as a one-cycle strobe
// and the result side never stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_arith_unit_core import vau_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_func,
    input  logic [2:0]         i_dim,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_a_w,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_b_w,
    output logic               o_done,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic signed [31:0] o_r_w,
    output logic [1:0]         o_fault
);

    localparam int DW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int FB = (FRAC_BITS > 30) ? 30 : FRAC_BITS;
    localparam int NW = 32 + FB;

    typedef struct packed {
        logic [NLANE-1:0][31:0] a;
        logic [31:0]            b0;
    } t_opnd;

    typedef struct packed {
        logic [NLANE-1:0][31:0] res;
        logic                   sat;
    } t_early;

    t_word  a [NLANE];
    t_word  b [NLANE];
    t_ctrl  n_ctl;
    t_opnd  n_opd;
    logic [2:0] n_lanes;

    t_ctrl  r_ctl   [T_DIV];
    logic   r_vld   [T_DIV];
    t_opnd  r_opd   [T_SQ];
    t_early r_early [T_DIV-3];
    t_early n_early;

    logic signed [63:0] lp0  [NLANE];
    t_sat               lres [NLANE];
    logic signed [64:0] mp   [NLANE];
    logic signed [64:0] r_pa, r_pb;
    logic signed [65:0] r_tot;
    t_sat               dd;

    logic [DVW-1:0]   mag;
    logic [QBITS-1:0] quo [NLANE];
    logic             ovf [NLANE];

    logic [NLANE-1:0][31:0] r_res, n_res;
    t_fault                 r_fault, n_fault;
    logic                   r_done;

    assign busy = 1'b0;

    assign a[0] = i_a_x;
    assign a[1] = i_a_y;
    assign a[2] = i_a_z;
    assign a[3] = i_a_w;
    assign b[0] = i_b_x;
    assign b[1] = i_b_y;
    assign b[2] = i_b_z;
    assign b[3] = i_b_w;

    // decode the command: lane masks and operand flags
    always_comb begin
        n_lanes = i_dim;
        if (i_dim < 3'd2) begin
            n_lanes = 3'd2;
        end else if (i_dim > 3'd4) begin
            n_lanes = 3'd4;
        end
        n_ctl.func  = t_func'(i_func);
        n_ctl.bzero = (b[0] == '0);
        n_ctl.bneg  = b[0][31];
        for (int i = 0; i < NLANE; i++) begin
            n_ctl.lane_use[i] = (3'(i) < n_lanes);
            case (n_ctl.func)
                FN_CROSS: n_ctl.out_en[i] = (i < 3);
                FN_DOT:   n_ctl.out_en[i] = (i == 0);
                default:  n_ctl.out_en[i] = n_ctl.lane_use[i];
            endcase
            n_ctl.azero[i] = (a[i] == '0);
            n_ctl.aneg[i]  = a[i][31];
            n_opd.a[i]     = a[i];
        end
        n_opd.b0 = b[0];
    end

    // control, valid and operand delay lines
    always_ff @(posedge i_clk) begin
        r_ctl[0] <= n_ctl;
        for (int k = 1; k < T_DIV; k++) begin
            r_ctl[k] <= r_ctl[k-1];
        end
        r_opd[0] <= n_opd;
        for (int k = 1; k < T_SQ; k++) begin
            r_opd[k] <= r_opd[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < T_DIV; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k < T_DIV; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_done <= r_vld[T_DIV-1];
        end
    end

    // lanes with their operand routing
    for (genvar i = 0; i < NLANE; i++) begin : g_lane
        localparam int LI = i % 3;
        logic signed [31:0] ma, mb, mc, md, ab;

        always_comb begin
            ma = a[i];
            mb = b[i];
            mc = '0;
            md = '0;
            ab = b[i];
            case (n_ctl.func)
                FN_CROSS: begin
                    ma = a[CP[LI][0]];
                    mb = b[CP[LI][1]];
                    mc = a[CP[LI][2]];
                    md = b[CP[LI][3]];
                end
                FN_SCALE:        mb = b[0];
                FN_NORM:         mb = a[i];
                FN_ADDS, FN_SUBS: ab = b[0];
                default: ;
            endcase
        end

        vau_lane #(
            .DW (DW),
            .FB (FB)
        ) u_lane (
            .i_clk  (i_clk),
            .i_func (n_ctl.func),
            .i_en   (n_ctl.out_en[i]),
            .i_ma   (ma),
            .i_mb   (mb),
            .i_mc   (mc),
            .i_md   (md),
            .i_a    (a[i]),
            .i_b    (ab),
            .i_sub  ((n_ctl.func == FN_SUB) || (n_ctl.func == FN_SUBS)),
            .o_p0   (lp0[i]),
            .o_res  (lres[i])
        );

        assign mp[i] = r_ctl[0].lane_use[i] ? {lp0[i][63], lp0[i]} : '0;
    end

    // merge: two-level sum of the lane products (dot, sum of squares)
    always_ff @(posedge i_clk) begin
        r_pa  <= mp[0] + mp[1];
        r_pb  <= mp[2] + mp[3];
        r_tot <= {r_pa[64], r_pa} + {r_pb[64], r_pb};
    end

    // combine lane results with the dot product
    always_comb begin
        dd      = sat_clamp(r_tot >>> FB, DW);
        n_early.sat = 1'b0;
        for (int i = 0; i < NLANE; i++) begin
            n_early.res[i] = lres[i].val;
            n_early.sat    = n_early.sat | lres[i].sat;
        end
        if (r_ctl[2].func == FN_DOT) begin
            n_early.res[0] = dd.val;
            n_early.sat    = dd.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_early[0] <= n_early;
        for (int k = 1; k < T_DIV - 3; k++) begin
            r_early[k] <= r_early[k-1];
        end
    end

    // magnitude for normalize
    vau_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_x     (r_tot[63:0]),
        .i_carry (r_tot[64]),
        .o_mag   (mag)
    );

    // one divider per lane, shared by divide and normalize
    for (genvar i = 0; i < NLANE; i++) begin : g_div
        logic [31:0]    abs_a, abs_b;
        logic [NW-1:0]  num;
        logic [DVW-1:0] den;

        assign abs_a = r_opd[T_SQ-1].a[i][31] ? 32'(-r_opd[T_SQ-1].a[i])
                                              : r_opd[T_SQ-1].a[i];
        assign abs_b = r_opd[T_SQ-1].b0[31] ? 32'(-r_opd[T_SQ-1].b0)
                                            : r_opd[T_SQ-1].b0;
        assign num   = {abs_a, {FB{1'b0}}};
        assign den   = (r_ctl[T_SQ-1].func == FN_NORM) ? mag : {1'b0, abs_b};

        vau_div #(
            .NW (NW)
        ) u_div (
            .i_clk (i_clk),
            .i_num (num),
            .i_den (den),
            .o_quo (quo[i]),
            .o_ovf (ovf[i])
        );
    end

    // final stage: signed quotients, zero and divide-by-zero rules, fault
    always_comb begin
        t_ctrl              c;
        t_early             e;
        logic               dz;
        logic               st;
        logic               sgn;
        logic signed [65:0] qv;
        t_sat               qs;
        c  = r_ctl[T_DIV-1];
        e  = r_early[T_DIV-4];
        dz = 1'b0;
        st = e.sat;
        for (int i = 0; i < NLANE; i++) begin
            n_res[i] = e.res[i];
            sgn = c.aneg[i] ^ ((c.func == FN_DIV) & c.bneg);
            qv  = sgn ? -$signed({33'd0, quo[i]}) : $signed({33'd0, quo[i]});
            qs  = sat_clamp(qv, DW);
            if (ovf[i]) begin
                qs.val = sgn ? min_val(DW) : max_val(DW);
                qs.sat = 1'b1;
            end
            case (c.func)
                FN_DIV: begin
                    n_res[i] = '0;
                    if (c.lane_use[i] && !c.azero[i]) begin
                        if (c.bzero) begin
                            dz       = 1'b1;
                            n_res[i] = c.aneg[i] ? min_val(DW) : max_val(DW);
                        end else begin
                            n_res[i] = qs.val;
                            st       = st | qs.sat;
                        end
                    end
                end
                FN_NORM: begin
                    n_res[i] = '0;
                    if (c.lane_use[i] && !c.azero[i]) begin
                        n_res[i] = qs.val;
                        st       = st | qs.sat;
                    end
                end
                default: ;
            endcase
        end
        if (dz) begin
            n_fault = FLT_DIVZ;
        end else if (st) begin
            n_fault = FLT_SAT;
        end else begin
            n_fault = FLT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_fault <= n_fault;
    end

    assign o_done  = r_done;
    assign o_r_x   = r_res[0];
    assign o_r_y   = r_res[1];
    assign o_r_z   = r_res[2];
    assign o_r_w   = r_res[3];
    assign o_fault = r_fault;

endmodule

`default_nettype wire

/* hdl/vau_lane.sv */
// ---------------------------------------------------------------------------
// vau_lane
// One element lane: two products, add/sub, cross difference, floor shift
// and saturation over three register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module vau_lane import vau_pkg::*; #(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  t_func              i_func,
    input  logic               i_en,
    input  logic signed [31:0] i_ma,
    input  logic signed [31:0] i_mb,
    input  logic signed [31:0] i_mc,
    input  logic signed [31:0] i_md,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic               i_sub,
    output logic signed [63:0] o_p0,
    output t_sat               o_res
);

    logic signed [63:0] r_p0, r_p1;
    logic signed [32:0] r_sum1, r_sum2;
    logic signed [64:0] r_x2;
    t_func              r_f1, r_f2;
    logic               r_en1, r_en2;
    t_sat               r_res, n_res;
    logic signed [32:0] n_sum;
    logic signed [65:0] x66, sh, sum66;

    // stage 1: products and element sum
    assign n_sum = i_sub ? ({i_a[31], i_a} - {i_b[31], i_b})
                         : ({i_a[31], i_a} + {i_b[31], i_b});

    always_ff @(posedge i_clk) begin
        r_p0   <= i_ma * i_mb;
        r_p1   <= i_mc * i_md;
        r_sum1 <= n_sum;
        r_f1   <= i_func;
        r_en1  <= i_en;
    end

    // stage 2: exact cross difference
    always_ff @(posedge i_clk) begin
        if (r_f1 == FN_CROSS) begin
            r_x2 <= {r_p0[63], r_p0} - {r_p1[63], r_p1};
        end else begin
            r_x2 <= {r_p0[63], r_p0};
        end
        r_sum2 <= r_sum1;
        r_f2   <= r_f1;
        r_en2  <= r_en1;
    end

    // stage 3: floor shift and saturate
    assign x66   = $signed({r_x2[64], r_x2});
    assign sh    = x66 >>> FB;
    assign sum66 = $signed({{33{r_sum2[32]}}, r_sum2});

    always_comb begin
        n_res = '0;
        case (r_f2)
            FN_ADD, FN_SUB, FN_ADDS, FN_SUBS: n_res = sat_clamp(sum66, DW);
            FN_CROSS, FN_SCALE:               n_res = sat_clamp(sh, DW);
            default:                          n_res = '0;
        endcase
        if (!r_en2) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_p0  = r_p0;
    assign o_res = r_res;

endmodule

`default_nettype wire

/* hdl/vau_isqrt.sv */
// ---------------------------------------------------------------------------
// vau_isqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage;
// a carry out of the sum forces the magnitude to 2^32.
// ---------------------------------------------------------------------------
`default_nettype none

module vau_isqrt import vau_pkg::*; (
    input  logic           i_clk,
    input  logic [63:0]    i_x,
    input  logic           i_carry,
    output logic [DVW-1:0] o_mag
);

    localparam int LAST = SQ_STG - 1;

    logic [33:0] r_rem  [SQ_STG-1];
    logic [63:0] r_x    [SQ_STG-1];
    logic [31:0] r_root [SQ_STG];
    logic        r_cy   [SQ_STG];

    for (genvar k = 0; k < SQ_STG; k++) begin : g_stg
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] x_in;
        logic        cy_in;
        logic [35:0] t, trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = i_x;
            assign cy_in   = i_carry;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign x_in    = r_x[k-1];
            assign cy_in   = r_cy[k-1];
        end

        // bring down two bits, try root*4+1
        assign t     = {rem_in, x_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            r_root[k] <= {root_in[30:0], ge};
            r_cy[k]   <= cy_in;
        end

        if (k < LAST) begin : g_pass
            always_ff @(posedge i_clk) begin
                r_rem[k] <= ge ? 34'(t - trial) : t[33:0];
                r_x[k]   <= {x_in[61:0], 2'b00};
            end
        end
    end

    assign o_mag = r_cy[LAST] ? {1'b1, 32'd0} : {1'b0, r_root[LAST]};

endmodule

`default_nettype wire

/* hdl/vau_div.sv */
// ---------------------------------------------------------------------------
// vau_div
// Pipelined unsigned restoring divider: an overflow check stage, then one
// quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module vau_div import vau_pkg::*; #(
    parameter int NW = 32 + FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic [NW-1:0]    i_num,
    input  logic [DVW-1:0]   i_den,
    output logic [QBITS-1:0] o_quo,
    output logic             o_ovf
);

    localparam int HW = NW - QBITS;

    logic [DVW-1:0]   r_rem [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_ovf [QBITS+1];
    logic [DVW-1:0]   r_den [QBITS];
    logic [QBITS-1:0] r_lo  [QBITS];

    // check stage: quotient overflows QBITS when the high part reaches den
    always_ff @(posedge i_clk) begin
        r_ovf[0] <= ({{(DVW + 1 - HW){1'b0}}, i_num[NW-1:QBITS]} >= {1'b0, i_den});
        r_rem[0] <= DVW'(i_num[NW-1:QBITS]);
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_lo[0]  <= i_num[QBITS-1:0];
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_stg
        logic [DVW:0] t, diff;
        logic         ge;

        assign t    = {r_rem[k-1], r_lo[k-1][QBITS-1]};
        assign diff = t - {1'b0, r_den[k-1]};
        assign ge   = (t >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[DVW-1:0] : t[DVW-1:0];
            r_q[k]   <= {r_q[k-1][QBITS-2:0], ge};
            r_ovf[k] <= r_ovf[k-1];
        end

        if (k < QBITS) begin : g_pass
            always_ff @(posedge i_clk) begin
                r_den[k] <= r_den[k-1];
                r_lo[k]  <= r_lo[k-1] << 1;
            end
        end
    end

    assign o_quo = r_q[QBITS];
    assign o_ovf = r_ovf[QBITS];

endmodule

`default_nettype wire

/* hdl/vau_checker.sv */
// ---------------------------------------------------------------------------
// vau_checker
// Port-level checks of the vector arithmetic unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "vector_arith_unit_core_defines.svh"

module vau_checker import vau_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [3:0]         i_func,
    input wire logic [2:0]         i_dim,
    input wire logic signed [31:0] i_a_x,
    input wire logic signed [31:0] i_a_y,
    input wire logic signed [31:0] i_a_z,
    input wire logic signed [31:0] i_a_w,
    input wire logic signed [31:0] i_b_x,
    input wire logic signed [31:0] i_b_y,
    input wire logic signed [31:0] i_b_z,
    input wire logic signed [31:0] i_b_w,
    input wire logic               o_done,
    input wire logic signed [31:0] o_r_x,
    input wire logic signed [31:0] o_r_y,
    input wire logic signed [31:0] o_r_z,
    input wire logic signed [31:0] o_r_w,
    input wire logic [1:0]         o_fault
);

    // every command transfer yields a result after the fixed latency
    `VAU_ASSERT_IMP(a_start_done, start && !busy, ##LATENCY o_done, "result missing")

    // no result without a command transfer
    `VAU_ASSERT_IMP(a_done_src, o_done, $past(start && !busy, LATENCY), "spurious result")

    // divide by zero only comes from the divide opcode
    `VAU_ASSERT_IMP(a_divz_src, o_done && o_fault == FLT_DIVZ,
        $past(i_func, LATENCY) == FN_DIV, "divide fault on other opcode")

    // cross product leaves w at zero
    `VAU_ASSERT_IMP(a_cross_w, o_done && $past(i_func, LATENCY) == FN_CROSS,
        o_r_w == '0, "cross product w not zero")

    // dot product uses only the x lane
    `VAU_ASSERT_NEVER(a_dot_lanes, o_done && $past(i_func, LATENCY) == FN_DOT &&
        (o_r_y != '0 || o_r_z != '0 || o_r_w != '0), "dot product upper lanes not zero")

endmodule

bind vector_arith_unit_core vau_checker u_vau_checker (.*);

`default_nettype wire

/* tb/vector_arith_unit_core_checker.sv */
// ---------------------------------------------------------------------------
// Vector arithmetic unit checker
// Watches the command and result channels, predicts each result from the
// accepted command and compares it lane by lane with what the unit returns.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_arith_unit_core_checker import vau_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [3:0]         i_func,
    input  logic [2:0]         i_dim,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_a_w,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_b_w,
    input  logic               o_done,
    input  logic signed [31:0] o_r_x,
    input  logic signed [31:0] o_r_y,
    input  logic signed [31:0] o_r_z,
    input  logic signed [31:0] o_r_w,
    input  logic [1:0]         o_fault,
    output int                 o_fail_cnt,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] lane [4];
        logic [1:0]  fault;
    } t_vec_result;

    typedef logic signed [79:0] t_wide;

    localparam t_wide WMAX = 80'sd2147483647;
    localparam t_wide WMIN = -80'sd2147483648;

    // cross product lanes: r[i] = a[j]*b[k] - a[k]*b[j]
    localparam int XJ [3] = '{1, 2, 0};
    localparam int XK [3] = '{2, 0, 1};

    t_vec_result result_q [$];

    function automatic logic [31:0] sat32(input t_wide v, inout bit sat);
        if (v > WMAX) begin
            sat = 1'b1;
            return WMAX[31:0];
        end
        if (v < WMIN) begin
            sat = 1'b1;
            return WMIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bt;
        res = 64'd0;
        bt  = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 64'd0) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic t_vec_result vec_compute(input logic [3:0] func, input logic [2:0] dim,
                                                input t_wide a [4], input t_wide b [4]);
        t_vec_result rs;
        bit          sat;
        bit          dz;
        int          n;
        t_wide       acc;
        t_wide       mag;
        logic [79:0] sq;
        sat = 1'b0;
        dz  = 1'b0;
        n   = (dim < 3'd2) ? 2 : ((dim > 3'd4) ? 4 : int'(dim));
        for (int i = 0; i < 4; i++) rs.lane[i] = 32'd0;
        case (func)
            FN_ADD, FN_SUB: begin
                for (int i = 0; i < n; i++)
                    rs.lane[i] = sat32(func == FN_ADD ? a[i] + b[i] : a[i] - b[i], sat);
            end
            FN_DOT: begin
                acc = 0;
                for (int i = 0; i < n; i++) acc = acc + a[i] * b[i];
                rs.lane[0] = sat32(acc >>> 16, sat);
            end
            FN_CROSS: begin
                for (int i = 0; i < 3; i++)
                    rs.lane[i] = sat32((a[XJ[i]] * b[XK[i]] - a[XK[i]] * b[XJ[i]]) >>> 16, sat);
            end
            FN_SCALE: begin
                for (int i = 0; i < n; i++) rs.lane[i] = sat32((a[i] * b[0]) >>> 16, sat);
            end
            FN_ADDS, FN_SUBS: begin
                for (int i = 0; i < n; i++)
                    rs.lane[i] = sat32(func == FN_ADDS ? a[i] + b[0] : a[i] - b[0], sat);
            end
            FN_DIV: begin
                for (int i = 0; i < n; i++) begin
                    if (a[i] == 0) begin
                        rs.lane[i] = 32'd0;
                    end else if (b[0] == 0) begin
                        dz = 1'b1;
                        rs.lane[i] = (a[i] > 0) ? WMAX[31:0] : WMIN[31:0];
                    end else begin
                        rs.lane[i] = sat32((a[i] <<< 16) / b[0], sat);
                    end
                end
            end
            FN_NORM: begin
                sq = 80'd0;
                for (int i = 0; i < n; i++) sq = sq + 80'(a[i] * a[i]);
                // sum beyond 64 bits takes a magnitude of 2^32
                if (sq >= (80'd1 << 64)) mag = 80'sd1 <<< 32;
                else mag = t_wide'({16'd0, root_floor(sq[63:0])});
                for (int i = 0; i < n; i++) begin
                    if (a[i] != 0 && mag != 0) rs.lane[i] = sat32((a[i] <<< 16) / mag, sat);
                end
            end
            default: ;
        endcase
        rs.fault = dz ? FLT_DIVZ : (sat ? FLT_SAT : FLT_NONE);
        return rs;
    endfunction

    assign o_pending = result_q.size();

    // predict on each command transfer, compare on each result strobe
    always @(posedge i_clk) begin
        t_wide       a [4];
        t_wide       b [4];
        t_vec_result exp_r;
        logic [31:0] got [4];
        string       nm [4];
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
        end else begin
            if (start && !busy) begin
                a = '{i_a_x, i_a_y, i_a_z, i_a_w};
                b = '{i_b_x, i_b_y, i_b_z, i_b_w};
                result_q.push_back(vec_compute(i_func, i_dim, a, b));
            end
            if (o_done) begin
                if (result_q.size() == 0) begin
                    $error("result with no command outstanding");
                    errs++;
                end else begin
                    exp_r = result_q.pop_front();
                    got   = '{o_r_x, o_r_y, o_r_z, o_r_w};
                    nm    = '{"r_x", "r_y", "r_z", "r_w"};
                    for (int i = 0; i < 4; i++) begin
                        if (got[i] !== exp_r.lane[i]) begin
                            $error("%s mismatch: expected %h actual %h",
                                   nm[i], exp_r.lane[i], got[i]);
                            errs++;
                        end
                    end
                    if (o_fault !== exp_r.fault) begin
                        $error("fault mismatch: expected %0d actual %0d", exp_r.fault, o_fault);
                        errs++;
                    end
                end
            end
            o_fail_cnt <= o_fail_cnt + errs;
        end
    end

endmodule

`default_nettype wire

/* tb/vector_arith_unit_core_tb.sv */
// ---------------------------------------------------------------------------
// Vector arithmetic unit testbench
// Directed corner commands, then random bursts of commands over all opcodes
// and dim codes; results are checked by the checker beside the unit.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_arith_unit_core_tb import vau_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 500;
    localparam int IDLE_LIMIT = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         i_func;
    logic [2:0]         i_dim;
    logic signed [31:0] i_a_x, i_a_y, i_a_z, i_a_w;
    logic signed [31:0] i_b_x, i_b_y, i_b_z, i_b_w;
    logic               o_done;
    logic signed [31:0] o_r_x, o_r_y, o_r_z, o_r_w;
    logic [1:0]         o_fault;
    int                 fail_cnt;
    int                 pending;
    int                 idle_cycles;
    int                 cmd_cnt;

    vector_arith_unit_core u_dut (.*);

    vector_arith_unit_core_checker u_checker (
        .*,
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mix of extremes, small Q16.16 values and raw random words
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h0001_0000;
            4:       return 32'hFFFF_0000;
            5:       return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    // drive one command and hold it until its transfer
    task automatic send_cmd(input logic [3:0] f, input logic [2:0] d,
                            input logic [31:0] ax, ay, az, aw, bx, by, bz, bw);
        start  <= 1'b1;
        i_func <= f;
        i_dim  <= d;
        i_a_x <= ax; i_a_y <= ay; i_a_z <= az; i_a_w <= aw;
        i_b_x <= bx; i_b_y <= by; i_b_z <= bz; i_b_w <= bw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cmd_cnt++;
    endtask

    task automatic idle_gap(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("vector_arith_unit_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int          burst;
        logic [31:0] sc;
        cmd_cnt = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_func  <= 4'd0;
        i_dim   <= 3'd0;
        i_a_x <= '0; i_a_y <= '0; i_a_z <= '0; i_a_w <= '0;
        i_b_x <= '0; i_b_y <= '0; i_b_z <= '0; i_b_w <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every opcode, overflow, divide by zero, zero vector
        for (int f = 0; f <= 8; f++)
            send_cmd(4'(f), 3'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_8000, 32'h0001_0000);
        send_cmd(FN_DIV, 3'd3, 32'h0001_0000, 32'd0, 32'hFFFF_0000, 32'd5, 32'd0, 0, 0, 0);
        send_cmd(FN_DIV, 3'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd0,
                 32'hFFFF_FFFF, 0, 0, 0);
        send_cmd(FN_NORM, 3'd4, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(FN_NORM, 3'd4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 0, 0, 0, 0);
        send_cmd(FN_NORM, 3'd2, 32'd3, 32'd4, 32'd7, 32'd9, 0, 0, 0, 0);
        send_cmd(FN_NORM, 3'd2, 32'd1, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(FN_DOT, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1,
                 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
        send_cmd(FN_ADD, 3'd7, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd3,
                 32'd1, 32'd1, 32'd1, 32'd1);
        send_cmd(FN_CROSS, 3'd2, 32'h0001_0000, 0, 0, 32'd9, 0, 32'h0001_0000, 0, 32'd9);
        send_cmd(FN_SUBS, 3'd1, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd1, 0, 0, 0);
        send_cmd(4'd9, 3'd4, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5);
        send_cmd(4'd15, 3'd3, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5);
        send_cmd(FN_SCALE, 3'd4, 32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF, 0, 0, 0);
        idle_gap(3);

        // random bursts; opcodes 0..8 dominate, unknown codes occasionally
        for (int k = 0; k < N_RANDOM; k += burst) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst; j++) begin
                sc = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_word();
                send_cmd(($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                      : 4'($urandom_range(0, 8)),
                         ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4)),
                         pick_word(), pick_word(), pick_word(), pick_word(),
                         sc, pick_word(), pick_word(), pick_word());
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
        end
        start <= 1'b0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Ran %0d commands: all opcodes incl. unknown codes, dim codes 0..7,", cmd_cnt);
        $display("saturation, divide by zero and zero vectors, random bursts and gaps.");
        if (fail_cnt == 0) begin
            $display("vector_arith_unit_core regression: pass");
        end else begin
            $display("vector_arith_unit_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
